// ===== design/axp_pkg.sv =====
// shared types, constants and character classes for the xml attribute parser
`default_nettype none
package axp_pkg;

    localparam int COUNT_W           = 12;
    localparam int COUNT_CAP         = 4095;
    localparam int MAX_COUNT_DEFAULT = 4095;
    localparam int CHAR_W            = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CHAR_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CHAR_UND   = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_DQUOT = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQUOT = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

    typedef enum logic [2:0] {
        TAG_IGN  = 3'd0,
        TAG_KEY  = 3'd1,
        TAG_SEP  = 3'd2,
        TAG_VAL  = 3'd3,
        TAG_DONE = 3'd4,
        TAG_ERR  = 3'd5
    } tag_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_BEGIN  = 6'b000010,
        PH_KEY    = 6'b000100,
        PH_PREEQ  = 6'b001000,
        PH_POSTEQ = 6'b010000,
        PH_VALUE  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic              start_req;
        logic [CHAR_W-1:0] char_code;
    } item_t;

    typedef struct packed {
        tag_t               tag;
        logic [CHAR_W-1:0]  char_out;
        logic [COUNT_W-1:0] consumed;
    } result_t;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == CHAR_SP || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
    endfunction

endpackage
`default_nettype wire

// ===== design/axp_in_stage.sv =====
// input register stage holding one accepted word
`default_nettype none
module axp_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          advance,
    output logic               valid,
    output axp_pkg::item_t     item
);
    import axp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready = !valid_reg || advance;
    assign valid    = valid_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.start_req <= s_tuser;
            item_reg.char_code <= s_tdata;
        end
    end

endmodule
`default_nettype wire

// ===== design/axp_step.sv =====
// parser state and per-character tagging logic
`default_nettype none
module axp_step #(
    parameter int MAX_COUNT = axp_pkg::MAX_COUNT_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire axp_pkg::item_t item,
    output axp_pkg::result_t   result
);
    import axp_pkg::*;

    localparam int SAT_LIMIT = (MAX_COUNT < COUNT_CAP) ? MAX_COUNT : COUNT_CAP;
    localparam logic [COUNT_W-1:0] SAT_VAL = COUNT_W'(SAT_LIMIT);

    phase_t             phase_reg, phase_next;
    logic               squote_reg, squote_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    phase_t             cur_phase;
    logic               cur_squote;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] count_inc;
    logic [CHAR_W-1:0]  c;
    logic [CHAR_W-1:0]  close_quote;
    tag_t               tag;

    always_comb
    begin
        c           = item.char_code;
        cur_phase   = item.start_req ? PH_BEGIN : phase_reg;
        cur_squote  = item.start_req ? 1'b0 : squote_reg;
        cur_count   = item.start_req ? '0 : count_reg;
        count_inc   = (cur_count < SAT_VAL) ? cur_count + 1'b1 : cur_count;
        close_quote = cur_squote ? CHAR_SQUOT : CHAR_DQUOT;

        tag         = TAG_IGN;
        phase_next  = cur_phase;
        squote_next = cur_squote;
        count_next  = cur_count;

        unique case (cur_phase)
            PH_BEGIN:
            begin
                if (c == CHAR_NUL)
                begin
                    tag = TAG_DONE; phase_next = PH_IDLE;
                end
                else if (is_alpha(c))
                begin
                    tag = TAG_KEY; count_next = count_inc; phase_next = PH_KEY;
                end
                else
                begin
                    tag = TAG_ERR; phase_next = PH_IDLE;
                end
            end
            PH_KEY:
            begin
                if (is_alpha(c) || is_digit(c) || c == CHAR_UND)
                begin
                    tag = TAG_KEY; count_next = count_inc;
                end
                else if (is_space(c))
                begin
                    tag = TAG_SEP; count_next = count_inc; phase_next = PH_PREEQ;
                end
                else if (c == CHAR_EQ)
                begin
                    tag = TAG_SEP; count_next = count_inc; phase_next = PH_POSTEQ;
                end
                else
                begin
                    tag = TAG_ERR; phase_next = PH_IDLE;
                end
            end
            PH_PREEQ:
            begin
                if (is_space(c))
                begin
                    tag = TAG_SEP; count_next = count_inc;
                end
                else if (c == CHAR_EQ)
                begin
                    tag = TAG_SEP; count_next = count_inc; phase_next = PH_POSTEQ;
                end
                else
                begin
                    tag = TAG_ERR; phase_next = PH_IDLE;
                end
            end
            PH_POSTEQ:
            begin
                if (is_space(c))
                begin
                    tag = TAG_SEP; count_next = count_inc;
                end
                else if (c == CHAR_DQUOT || c == CHAR_SQUOT)
                begin
                    tag         = TAG_SEP;
                    count_next  = count_inc;
                    squote_next = (c == CHAR_SQUOT);
                    phase_next  = PH_VALUE;
                end
                else
                begin
                    tag = TAG_ERR; phase_next = PH_IDLE;
                end
            end
            PH_VALUE:
            begin
                if (c == CHAR_NUL)
                begin
                    tag = TAG_DONE; phase_next = PH_IDLE;
                end
                else if (c == CHAR_LT || c == CHAR_AMP)
                begin
                    tag = TAG_ERR; phase_next = PH_IDLE;
                end
                else if (c == close_quote)
                begin
                    tag = TAG_DONE; count_next = count_inc; phase_next = PH_IDLE;
                end
                else
                begin
                    tag = TAG_VAL; count_next = count_inc;
                end
            end
            default:
            begin
                tag        = TAG_IGN;
                phase_next = PH_IDLE;
            end
        endcase

        result.tag      = tag;
        result.char_out = c;
        result.consumed = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            squote_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            squote_reg <= squote_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/axp_out_stage.sv =====
// result register driving the output stream
`default_nettype none
module axp_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire axp_pkg::result_t result,
    output logic                  ready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata,
    output logic [2:0]            m_tuser
);
    import axp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.tag;
    assign m_tdata  = {4'b0000, result_reg.consumed, result_reg.char_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

// ===== design/xml_attribute_char_parser_core.sv =====
// top level of the streaming xml attribute character parser
// Checks one attribute of the form key = value, one character per word, and tags
// each character as ignored, key, separator, value, finished or error, with a
// saturating count of bytes consumed. Each word passes from the input register
// through the step logic into the result register, and a word can be accepted
// every cycle while the result register is not stalled. s_tuser high restarts
// the parser on that word.
`default_nettype none
module xml_attribute_char_parser_core #(
    parameter int MAX_COUNT = axp_pkg::MAX_COUNT_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code
    input  wire logic        s_tuser,   // start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // char_out, consumed, zero pad
    output logic [2:0]       m_tuser    // tag
);
    import axp_pkg::*;

    localparam int SAT_LIMIT = (MAX_COUNT < COUNT_CAP) ? MAX_COUNT : COUNT_CAP;
    localparam logic [COUNT_W-1:0] SAT_VAL = COUNT_W'(SAT_LIMIT);

    logic    in_valid;
    item_t   in_item;
    logic    out_ready;
    logic    step_fire;
    result_t step_result;

    assign step_fire = in_valid && out_ready;

    axp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (out_ready),
        .valid    (in_valid),
        .item     (in_item)
    );

    axp_step #(
        .MAX_COUNT (MAX_COUNT)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (step_fire),
        .item   (in_item),
        .result (step_result)
    );

    axp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step_fire),
        .result   (step_result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // count never passes the saturation limit
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:8] <= SAT_VAL))
        else $error("consumed count above saturation limit");

    // an accepted key, separator or value character is always counted
    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == TAG_KEY || m_tuser == TAG_SEP || m_tuser == TAG_VAL))
        |-> (m_tdata[19:8] != '0))
        else $error("counted character shows zero count");

    // a stalled result blocks the step logic
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !step_fire)
        else $error("step fired while result stalled");

endmodule
`default_nettype wire
